[rtl/segi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_pkg
// Widths, stage counts, types and the divider step shared by the segment
// intersection pipeline.
// ----------------------------------------------------------------------------
package segi_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int OUT_BITS   = 24;

    // coordinate difference, product of two differences, cross product
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    // partial products of the point numerator and their sum
    localparam int PT_W    = DIFF_W + CROSS_W;
    localparam int TOT_W   = PT_W + 1;
    // dividend after the fraction shift
    localparam int NRAW_W  = TOT_W + FRAC_BITS;
    localparam int DIVN_W  = (NRAW_W > OUT_BITS) ? NRAW_W : OUT_BITS + 1;
    localparam int HI_W    = DIVN_W - OUT_BITS;
    localparam int CMP_W   = (HI_W > CROSS_W) ? HI_W : CROSS_W;

    // quotient bits resolved per divider stage
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = (OUT_BITS + DIV_STEPS - 1) / DIV_STEPS;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    // front end result: point numerator magnitudes and divisor magnitude
    typedef struct packed {
        logic               hit;
        logic               pv;
        logic               neg_x;
        logic               neg_y;
        logic [TOT_W-1:0]   mag_x;
        logic [TOT_W-1:0]   mag_y;
        logic [CROSS_W-1:0] dm;
    } t_front;

    // one lane of the long division; sh holds dividend bits, then quotient
    typedef struct packed {
        logic               ovf;
        logic               neg;
        logic [CROSS_W-1:0] rem;
        logic [OUT_BITS-1:0] sh;
    } t_lane;

    typedef struct packed {
        logic               hit;
        logic               pv;
        logic [CROSS_W-1:0] dm;
        t_lane              lx;
        t_lane              ly;
    } t_div;

    // one restoring division step: bring down a bit, subtract if it fits
    function automatic t_lane div_step(input t_lane l, input logic [CROSS_W-1:0] dm);
        logic [CROSS_W:0] t;
        logic             q;
        t_lane            r;
        r = l;
        t = {l.rem, l.sh[OUT_BITS-1]};
        q = (t >= {1'b0, dm});
        if (q) begin
            t = t - {1'b0, dm};
        end
        r.rem = t[CROSS_W-1:0];
        r.sh  = {l.sh[OUT_BITS-2:0], q};
        return r;
    endfunction

endpackage

[rtl/segi_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_in_if
// Input channel: two segments AB and CD with valid/ready.
// ----------------------------------------------------------------------------
interface segi_in_if import segi_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord a_x;
    t_coord a_y;
    t_coord b_x;
    t_coord b_y;
    t_coord c_x;
    t_coord c_y;
    t_coord d_x;
    t_coord d_y;

    modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y,
                    input ready);
    modport sink   (input valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y,
                    output ready);
endinterface

[rtl/segi_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_out_if
// Result channel: hit flag and crossing point with valid/ready.
// ----------------------------------------------------------------------------
interface segi_out_if import segi_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic                       point_valid;
    logic signed [OUT_BITS-1:0] point_x;
    logic signed [OUT_BITS-1:0] point_y;

    modport source (output valid, hit, point_valid, point_x, point_y, input ready);
    modport sink   (input valid, hit, point_valid, point_x, point_y, output ready);
endinterface

[rtl/segi_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_front
// Five-stage front end: differences, products, cross products, hit test and
// point numerator products, then sign and magnitude for the divider.
// ----------------------------------------------------------------------------
module segi_front import segi_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_coord i_ax,
    input  t_coord i_ay,
    input  t_coord i_bx,
    input  t_coord i_by,
    input  t_coord i_cx,
    input  t_coord i_cy,
    input  t_coord i_dx,
    input  t_coord i_dy,
    output logic   o_valid,
    input  logic   i_ready,
    output t_front o_data
);

    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [CROSS_W-1:0] t_cross;
    typedef logic signed [PT_W-1:0]    t_pt;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic e1, e2, e3, e4, e5;

    // stage 1 registers
    t_coord r1_ax, r1_ay;
    t_diff  r1_abx, r1_aby, r1_acx, r1_acy, r1_adx, r1_ady;
    t_diff  r1_cdx, r1_cdy, r1_cax, r1_cay, r1_cbx, r1_cby;
    logic [3:0] r1_box, n1_box;
    // stage 2 registers
    t_coord r2_ax, r2_ay;
    t_diff  r2_abx, r2_aby;
    logic [3:0] r2_box;
    t_prod  r2_c1, r2_c2, r2_d1, r2_d2, r2_a1, r2_a2, r2_b1, r2_b2;
    t_prod  r2_n1, r2_n2, r2_m1, r2_m2;
    // stage 3 registers
    t_coord r3_ax, r3_ay;
    t_diff  r3_abx, r3_aby;
    logic [3:0] r3_box;
    t_cross r3_sc, r3_sd, r3_sa, r3_sb, r3_den, r3_num;
    // stage 4 registers
    logic   r4_hit, r4_pv, r4_dneg;
    t_pt    r4_px0, r4_px1, r4_py0, r4_py1;
    logic [CROSS_W-1:0] r4_dm;
    logic   n4_hit;
    // stage 5 register
    t_front r5, n5;

    logic signed [TOT_W-1:0] tot_x, tot_y;

    // advance a stage when it is empty or the next one advances
    assign e5 = !r_v5 || i_ready;
    assign e4 = !r_v4 || e5;
    assign e3 = !r_v3 || e4;
    assign e2 = !r_v2 || e3;
    assign e1 = !r_v1 || e2;
    assign o_ready = e1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (e1) r_v1 <= i_valid;
            if (e2) r_v2 <= r_v1;
            if (e3) r_v3 <= r_v2;
            if (e4) r_v4 <= r_v3;
            if (e5) r_v5 <= r_v4;
        end
    end

    // bounding box checks for each endpoint against the other segment
    always_comb begin
        n1_box[0] = ((i_cx >= i_ax && i_cx <= i_bx) || (i_cx >= i_bx && i_cx <= i_ax)) &&
                    ((i_cy >= i_ay && i_cy <= i_by) || (i_cy >= i_by && i_cy <= i_ay));
        n1_box[1] = ((i_dx >= i_ax && i_dx <= i_bx) || (i_dx >= i_bx && i_dx <= i_ax)) &&
                    ((i_dy >= i_ay && i_dy <= i_by) || (i_dy >= i_by && i_dy <= i_ay));
        n1_box[2] = ((i_ax >= i_cx && i_ax <= i_dx) || (i_ax >= i_dx && i_ax <= i_cx)) &&
                    ((i_ay >= i_cy && i_ay <= i_dy) || (i_ay >= i_dy && i_ay <= i_cy));
        n1_box[3] = ((i_bx >= i_cx && i_bx <= i_dx) || (i_bx >= i_dx && i_bx <= i_cx)) &&
                    ((i_by >= i_cy && i_by <= i_dy) || (i_by >= i_dy && i_by <= i_cy));
    end

    // stage 1: coordinate differences
    always_ff @(posedge i_clk) begin
        if (e1) begin
            r1_ax  <= i_ax;
            r1_ay  <= i_ay;
            r1_abx <= DIFF_W'(i_bx) - DIFF_W'(i_ax);
            r1_aby <= DIFF_W'(i_by) - DIFF_W'(i_ay);
            r1_acx <= DIFF_W'(i_cx) - DIFF_W'(i_ax);
            r1_acy <= DIFF_W'(i_cy) - DIFF_W'(i_ay);
            r1_adx <= DIFF_W'(i_dx) - DIFF_W'(i_ax);
            r1_ady <= DIFF_W'(i_dy) - DIFF_W'(i_ay);
            r1_cdx <= DIFF_W'(i_dx) - DIFF_W'(i_cx);
            r1_cdy <= DIFF_W'(i_dy) - DIFF_W'(i_cy);
            r1_cax <= DIFF_W'(i_ax) - DIFF_W'(i_cx);
            r1_cay <= DIFF_W'(i_ay) - DIFF_W'(i_cy);
            r1_cbx <= DIFF_W'(i_bx) - DIFF_W'(i_cx);
            r1_cby <= DIFF_W'(i_by) - DIFF_W'(i_cy);
            r1_box <= n1_box;
        end
    end

    // stage 2: products of differences
    always_ff @(posedge i_clk) begin
        if (e2) begin
            r2_ax  <= r1_ax;
            r2_ay  <= r1_ay;
            r2_abx <= r1_abx;
            r2_aby <= r1_aby;
            r2_box <= r1_box;
            r2_c1  <= PROD_W'(r1_abx) * PROD_W'(r1_acy);
            r2_c2  <= PROD_W'(r1_aby) * PROD_W'(r1_acx);
            r2_d1  <= PROD_W'(r1_abx) * PROD_W'(r1_ady);
            r2_d2  <= PROD_W'(r1_aby) * PROD_W'(r1_adx);
            r2_a1  <= PROD_W'(r1_cdx) * PROD_W'(r1_cay);
            r2_a2  <= PROD_W'(r1_cdy) * PROD_W'(r1_cax);
            r2_b1  <= PROD_W'(r1_cdx) * PROD_W'(r1_cby);
            r2_b2  <= PROD_W'(r1_cdy) * PROD_W'(r1_cbx);
            r2_n1  <= PROD_W'(r1_cdx) * PROD_W'(r1_aby);
            r2_n2  <= PROD_W'(r1_cdy) * PROD_W'(r1_abx);
            r2_m1  <= PROD_W'(r1_cdx) * PROD_W'(r1_acy);
            r2_m2  <= PROD_W'(r1_cdy) * PROD_W'(r1_acx);
        end
    end

    // stage 3: cross products, denominator and numerator
    always_ff @(posedge i_clk) begin
        if (e3) begin
            r3_ax  <= r2_ax;
            r3_ay  <= r2_ay;
            r3_abx <= r2_abx;
            r3_aby <= r2_aby;
            r3_box <= r2_box;
            r3_sc  <= CROSS_W'(r2_c1) - CROSS_W'(r2_c2);
            r3_sd  <= CROSS_W'(r2_d1) - CROSS_W'(r2_d2);
            r3_sa  <= CROSS_W'(r2_a1) - CROSS_W'(r2_a2);
            r3_sb  <= CROSS_W'(r2_b1) - CROSS_W'(r2_b2);
            r3_den <= CROSS_W'(r2_n1) - CROSS_W'(r2_n2);
            r3_num <= CROSS_W'(r2_m1) - CROSS_W'(r2_m2);
        end
    end

    // classify endpoints: touching, or proper crossing on both lines
    always_comb begin
        n4_hit = (r3_sc == '0 && r3_box[0]) || (r3_sd == '0 && r3_box[1]) ||
                 (r3_sa == '0 && r3_box[2]) || (r3_sb == '0 && r3_box[3]) ||
                 (r3_sc != '0 && r3_sd != '0 && (r3_sc[CROSS_W-1] != r3_sd[CROSS_W-1]) &&
                  r3_sa != '0 && r3_sb != '0 && (r3_sa[CROSS_W-1] != r3_sb[CROSS_W-1]));
    end

    // stage 4: hit flags and point numerator products A*den + (B-A)*num
    always_ff @(posedge i_clk) begin
        if (e4) begin
            r4_hit  <= n4_hit;
            r4_pv   <= n4_hit && (r3_den != '0);
            r4_dneg <= r3_den[CROSS_W-1];
            r4_dm   <= r3_den[CROSS_W-1] ? (CROSS_W'(0) - r3_den) : r3_den;
            r4_px0  <= PT_W'(r3_ax) * PT_W'(r3_den);
            r4_px1  <= PT_W'(r3_abx) * PT_W'(r3_num);
            r4_py0  <= PT_W'(r3_ay) * PT_W'(r3_den);
            r4_py1  <= PT_W'(r3_aby) * PT_W'(r3_num);
        end
    end

    // sum, then split into sign and magnitude
    always_comb begin
        tot_x    = TOT_W'(r4_px0) + TOT_W'(r4_px1);
        tot_y    = TOT_W'(r4_py0) + TOT_W'(r4_py1);
        n5.hit   = r4_hit;
        n5.pv    = r4_pv;
        n5.dm    = r4_dm;
        n5.neg_x = tot_x[TOT_W-1] ^ r4_dneg;
        n5.neg_y = tot_y[TOT_W-1] ^ r4_dneg;
        n5.mag_x = tot_x[TOT_W-1] ? (TOT_W'(0) - tot_x) : tot_x;
        n5.mag_y = tot_y[TOT_W-1] ? (TOT_W'(0) - tot_y) : tot_y;
    end

    // stage 5
    always_ff @(posedge i_clk) begin
        if (e5) begin
            r5 <= n5;
        end
    end

    assign o_valid = r_v5;
    assign o_data  = r5;

endmodule

[rtl/segi_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_div
// Pipelined restoring divider, two lanes (x and y) sharing one divisor.
// A setup stage checks for quotient overflow, then each stage resolves
// DIV_STEPS quotient bits.
// ----------------------------------------------------------------------------
module segi_div import segi_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_front i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_div   o_data
);

    logic r_v  [0:DIV_STAGES];
    t_div r_st [0:DIV_STAGES];
    logic e    [0:DIV_STAGES+1];
    t_div n_st [0:DIV_STAGES];

    logic [DIVN_W-1:0] nx, ny;
    logic [CMP_W-1:0]  hx, hy, dmx;

    assign e[DIV_STAGES+1] = i_ready;
    assign o_ready = e[0];

    // setup: shift in the fraction, test for overflow, seed the remainder
    always_comb begin
        nx  = DIVN_W'(i_data.mag_x) << FRAC_BITS;
        ny  = DIVN_W'(i_data.mag_y) << FRAC_BITS;
        hx  = CMP_W'(nx[DIVN_W-1:OUT_BITS]);
        hy  = CMP_W'(ny[DIVN_W-1:OUT_BITS]);
        dmx = CMP_W'(i_data.dm);
        n_st[0].hit    = i_data.hit;
        n_st[0].pv     = i_data.pv;
        n_st[0].dm     = i_data.dm;
        n_st[0].lx.ovf = (hx >= dmx);
        n_st[0].lx.neg = i_data.neg_x;
        n_st[0].lx.rem = CROSS_W'(hx);
        n_st[0].lx.sh  = nx[OUT_BITS-1:0];
        n_st[0].ly.ovf = (hy >= dmx);
        n_st[0].ly.neg = i_data.neg_y;
        n_st[0].ly.rem = CROSS_W'(hy);
        n_st[0].ly.sh  = ny[OUT_BITS-1:0];
    end

    genvar s;
    generate
        for (s = 1; s <= DIV_STAGES; s++) begin : g_stage
            // resolve the quotient bits of this stage
            always_comb begin
                n_st[s] = r_st[s-1];
                for (int j = 0; j < DIV_STEPS; j++) begin
                    if ((s - 1) * DIV_STEPS + j < OUT_BITS) begin
                        n_st[s].lx = div_step(n_st[s].lx, r_st[s-1].dm);
                        n_st[s].ly = div_step(n_st[s].ly, r_st[s-1].dm);
                    end
                end
            end
        end
        for (s = 0; s <= DIV_STAGES; s++) begin : g_reg
            assign e[s] = !r_v[s] || e[s+1];

            // hold on stall, advance otherwise
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (e[s]) begin
                    r_v[s] <= (s == 0) ? i_valid : r_v[(s == 0) ? 0 : s-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (e[s]) begin
                    r_st[s] <= n_st[s];
                end
            end
        end
    endgenerate

    assign o_valid = r_v[DIV_STAGES];
    assign o_data  = r_st[DIV_STAGES];

endmodule

[rtl/segment_intersection.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection
// 2-D segment intersection test with fixed-point crossing point.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  i_seg    | in  | valid / ready | a_x a_y b_x b_y c_x c_y d_x d_y (signed)
//  o_res    | out | valid / ready | hit point_valid point_x point_y
//
//  One transaction per cycle while o_res is ready; 5 front-end stages, divider
//  setup plus DIV_STAGES stages of DIV_STEPS quotient bits, output register.
//  Synchronous active-low reset clears the valid bits of every stage.
//  Each stage advances when empty or when its successor advances, so
//  bubbles close up under a stall and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module segment_intersection import segi_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    segi_in_if.sink   i_seg,
    segi_out_if.source o_res
);

    localparam logic [OUT_BITS-1:0] HALF = OUT_BITS'(1) << (OUT_BITS - 1);
    localparam logic [OUT_BITS-1:0] MAXP = HALF - OUT_BITS'(1);

    logic   f_valid, f_ready;
    t_front f_data;
    logic   d_valid, d_ready;
    t_div   d_data;

    logic   r_out_valid;
    logic   r_hit, r_pv;
    logic [OUT_BITS-1:0] r_px, r_py, n_px, n_py;
    logic   e_out;

    segi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_seg.valid),
        .o_ready (i_seg.ready),
        .i_ax    (i_seg.a_x),
        .i_ay    (i_seg.a_y),
        .i_bx    (i_seg.b_x),
        .i_by    (i_seg.b_y),
        .i_cx    (i_seg.c_x),
        .i_cy    (i_seg.c_y),
        .i_dx    (i_seg.d_x),
        .i_dy    (i_seg.d_y),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_data  (f_data)
    );

    segi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_data),
        .o_valid (d_valid),
        .i_ready (d_ready),
        .o_data  (d_data)
    );

    assign e_out   = !r_out_valid || o_res.ready;
    assign d_ready = e_out;

    // apply sign and saturate; zero the point when undefined
    always_comb begin
        n_px = '0;
        n_py = '0;
        if (d_data.pv) begin
            if (d_data.lx.neg) begin
                n_px = (d_data.lx.ovf || d_data.lx.sh > HALF) ? HALF
                                                             : OUT_BITS'(0) - d_data.lx.sh;
            end else begin
                n_px = (d_data.lx.ovf || d_data.lx.sh > MAXP) ? MAXP : d_data.lx.sh;
            end
            if (d_data.ly.neg) begin
                n_py = (d_data.ly.ovf || d_data.ly.sh > HALF) ? HALF
                                                             : OUT_BITS'(0) - d_data.ly.sh;
            end else begin
                n_py = (d_data.ly.ovf || d_data.ly.sh > MAXP) ? MAXP : d_data.ly.sh;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (e_out) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_out) begin
            r_hit <= d_data.hit;
            r_pv  <= d_data.pv;
            r_px  <= n_px;
            r_py  <= n_py;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.hit         = r_hit;
    assign o_res.point_valid = r_pv;
    assign o_res.point_x     = r_px;
    assign o_res.point_y     = r_py;

endmodule

[rtl/segi_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module segi_checker import segi_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic                i_hit,
    input logic                i_pv,
    input logic [OUT_BITS-1:0] i_px,
    input logic [OUT_BITS-1:0] i_py
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable({i_hit, i_pv, i_px, i_py}))
        else $error("result changed while stalled");

    // a defined point needs a hit
    a_pv_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_pv |-> i_hit)
        else $error("point valid without hit");

    // an undefined point reads as zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_pv |-> i_px == '0 && i_py == '0)
        else $error("undefined point not zero");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind segment_intersection segi_checker u_segi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_hit       (o_res.hit),
    .i_pv        (o_res.point_valid),
    .i_px        (o_res.point_x),
    .i_py        (o_res.point_y)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for segment_intersection. Directed corner pairs, then random
// pairs biased toward crossings, touches and collinear cases, are fed with
// random gaps. A behavioral predictor computes the hit flag and the
// fixed-point crossing point; the monitor compares each result in order.
// ----------------------------------------------------------------------------
module tb_top;
    import segi_pkg::*;

    typedef struct {
        logic signed [15:0] ax, ay, bx, by, cx, cy, dx, dy;
    } t_pair;

    typedef struct {
        logic               hit;
        logic               pv;
        logic signed [23:0] px;
        logic signed [23:0] py;
    } t_isect;

    logic i_clk;
    logic i_rst_n;

    segi_in_if  seg_if ();
    segi_out_if res_if ();

    segment_intersection u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_if.sink),
        .o_res   (res_if.source)
    );

    t_pair  pending_pairs[$];
    t_isect expected_isects[$];
    int     n_errors;
    int     idle_cycles;
    bit     stim_done;
    bit     hold_send;
    int     send_gap;
    int     recv_gap;
    bit     in_taken;
    bit     out_taken;

    // exact 2-D cross product (o->p) x (o->q)
    function automatic longint cross3(longint ox, longint oy, longint px,
                                      longint py, longint qx, longint qy);
        return (px - ox) * (qy - oy) - (py - oy) * (qx - ox);
    endfunction

    function automatic bit on_segment(longint px, longint py, longint qx,
                                      longint qy, longint rx, longint ry);
        if (cross3(px, py, qx, qy, rx, ry) != 0) return 0;
        if (rx < ((px < qx) ? px : qx) || rx > ((px < qx) ? qx : px)) return 0;
        if (ry < ((py < qy) ? py : qy) || ry > ((py < qy) ? qy : py)) return 0;
        return 1;
    endfunction

    // trunc((p0*(den-num) + p1*num) * 2^FRAC / den), saturated to 24 bits
    function automatic logic signed [23:0] crossing_coord(longint p0, longint p1,
                                                         longint num, longint den);
        logic signed [127:0] tot;
        logic signed [127:0] q;
        tot = (128'(signed'(p0)) * 128'(signed'(den - num)) +
               128'(signed'(p1)) * 128'(signed'(num))) * (128'sd1 <<< FRAC_BITS);
        q = tot / 128'(signed'(den));
        if (q > 128'sd8388607) return 24'sh7FFFFF;
        if (q < -128'sd8388608) return 24'sh800000;
        return q[23:0];
    endfunction

    function automatic t_isect predict_isect(t_pair p);
        t_isect r;
        longint ax, ay, bx, by, cx, cy, dx, dy, den, num;
        longint sc, sd, sa, sb;
        ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
        cx = p.cx; cy = p.cy; dx = p.dx; dy = p.dy;
        sc = cross3(ax, ay, bx, by, cx, cy);
        sd = cross3(ax, ay, bx, by, dx, dy);
        sa = cross3(cx, cy, dx, dy, ax, ay);
        sb = cross3(cx, cy, dx, dy, bx, by);
        r = '{0, 0, 0, 0};
        r.hit = on_segment(ax, ay, bx, by, cx, cy) || on_segment(ax, ay, bx, by, dx, dy) ||
                on_segment(cx, cy, dx, dy, ax, ay) || on_segment(cx, cy, dx, dy, bx, by) ||
                (((sc > 0 && sd < 0) || (sc < 0 && sd > 0)) &&
                 ((sa > 0 && sb < 0) || (sa < 0 && sb > 0)));
        if (!r.hit) return r;
        den = (dx - cx) * (by - ay) - (dy - cy) * (bx - ax);
        num = (dx - cx) * (cy - ay) - (dy - cy) * (cx - ax);
        if (den == 0) return r;
        r.pv = 1;
        r.px = crossing_coord(ax, bx, num, den);
        r.py = crossing_coord(ay, by, num, den);
        return r;
    endfunction

    function automatic logic signed [15:0] rand_coord(int span);
        if (span == 0) return 16'($urandom);
        return 16'($urandom_range(2 * span) - span);
    endfunction

    // crossing, shared endpoint, collinear, parallel or free segments
    function automatic t_pair rand_pair();
        t_pair p;
        int    span;
        int    kind;
        int    k;
        span = ($urandom_range(3) == 0) ? 0 : (($urandom_range(1) == 0) ? 8 : 2000);
        kind = $urandom_range(9);
        p.ax = rand_coord(span); p.ay = rand_coord(span);
        p.bx = rand_coord(span); p.by = rand_coord(span);
        p.cx = rand_coord(span); p.cy = rand_coord(span);
        p.dx = rand_coord(span); p.dy = rand_coord(span);
        if (kind < 4) begin
            // mirror C and D in x about the middle of AB so they straddle AB often
            p.cx = p.ax + p.bx - p.cx;
            p.dx = p.ax + p.bx - p.dx;
        end else if (kind == 4) begin
            p.cx = p.bx; p.cy = p.by;
        end else if (kind == 5) begin
            k = $urandom_range(4) - 2;
            p.cx = p.ax + (p.bx - p.ax) * k;
            p.cy = p.ay + (p.by - p.ay) * k;
            k = $urandom_range(4) - 2;
            p.dx = p.ax + (p.bx - p.ax) * k;
            p.dy = p.ay + (p.by - p.ay) * k;
        end else if (kind == 6) begin
            p.dx = p.cx + p.bx - p.ax; p.dy = p.cy + p.by - p.ay;
        end
        return p;
    endfunction

    // clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // stimulus
    initial begin
        t_pair p;
        i_rst_n   = 0;
        stim_done = 0;
        hold_send = 0;
        // crossing X
        pending_pairs.push_back('{-10, -10, 10, 10, -10, 10, 10, -10});
        // extremes of the range, crossing at (-0.5, -0.5)
        pending_pairs.push_back('{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768});
        pending_pairs.push_back('{32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767});
        // no hit: disjoint
        pending_pairs.push_back('{0, 0, 1, 0, 5, 5, 6, 6});
        // endpoint touch (T shape)
        pending_pairs.push_back('{0, 0, 10, 0, 5, 0, 5, 7});
        // shared endpoint
        pending_pairs.push_back('{0, 0, 4, 4, 4, 4, 9, -3});
        // collinear overlap, zero denominator
        pending_pairs.push_back('{0, 0, 10, 0, 5, 0, 20, 0});
        // collinear, disjoint
        pending_pairs.push_back('{0, 0, 10, 0, 11, 0, 20, 0});
        // parallel, no hit
        pending_pairs.push_back('{0, 0, 10, 0, 0, 1, 10, 1});
        // zero-length segment on the other
        pending_pairs.push_back('{3, 3, 3, 3, 0, 0, 6, 6});
        pending_pairs.push_back('{7, 7, 7, 7, 7, 7, 7, 7});
        // zero-length segment off the other
        pending_pairs.push_back('{3, 4, 3, 4, 0, 0, 6, 6});
        // fractional crossing, negative truncation
        pending_pairs.push_back('{0, 0, 3, 1, 1, 1, 2, -2});
        pending_pairs.push_back('{0, 0, -3, -1, -1, -1, -2, 2});
        // near miss of an endpoint, then a full-range crossing
        pending_pairs.push_back('{0, 0, 10, 10, 11, 11, 20, 0});
        pending_pairs.push_back('{-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767});
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        for (int i = 0; i < 650; i++) begin
            p = rand_pair();
            pending_pairs.push_back(p);
            if (i == 300) begin
                // drain the pipeline before going on
                wait (pending_pairs.size() == 0);
                hold_send = 1;
                @(posedge i_clk);
                wait (!seg_if.valid);
                wait (expected_isects.size() == 0);
                @(negedge i_clk);
                hold_send = 0;
            end
        end
        stim_done = 1;
    end

    // record the handshakes seen at the rising edge
    always @(posedge i_clk) begin
        in_taken  <= seg_if.valid && seg_if.ready;
        out_taken <= res_if.valid && res_if.ready;
    end

    // driver: present items at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            seg_if.valid <= 0;
            seg_if.a_x <= 0; seg_if.a_y <= 0; seg_if.b_x <= 0; seg_if.b_y <= 0;
            seg_if.c_x <= 0; seg_if.c_y <= 0; seg_if.d_x <= 0; seg_if.d_y <= 0;
            send_gap <= $urandom_range(4);
        end else if (seg_if.valid && !in_taken) begin
            // hold until accepted
        end else if (send_gap > 0 || hold_send || pending_pairs.size() == 0) begin
            seg_if.valid <= 0;
            if (send_gap > 0) send_gap <= send_gap - 1;
        end else begin
            t_pair p;
            p = pending_pairs.pop_front();
            seg_if.valid <= 1;
            seg_if.a_x <= p.ax; seg_if.a_y <= p.ay; seg_if.b_x <= p.bx; seg_if.b_y <= p.by;
            seg_if.c_x <= p.cx; seg_if.c_y <= p.cy; seg_if.d_x <= p.dx; seg_if.d_y <= p.dy;
            send_gap <= ($urandom_range(2) == 0) ? $urandom_range(4) : 0;
        end
    end

    // sink readiness: draw a wait after each result transaction
    always @(negedge i_clk) begin
        int draw;
        if (!i_rst_n) begin
            res_if.ready <= 0;
            recv_gap <= 0;
        end else if (recv_gap > 0) begin
            res_if.ready <= 0;
            recv_gap <= recv_gap - 1;
        end else if (out_taken) begin
            draw = ($urandom_range(2) == 0) ? $urandom_range(4) : 0;
            recv_gap <= (draw > 0) ? draw - 1 : 0;
            res_if.ready <= (draw == 0);
        end else begin
            res_if.ready <= 1;
        end
    end

    // monitor: predict on input transaction, check on output transaction
    always @(posedge i_clk) begin
        t_isect e;
        if (i_rst_n) begin
            if (seg_if.valid && seg_if.ready)
                expected_isects.push_back(predict_isect('{seg_if.a_x, seg_if.a_y,
                    seg_if.b_x, seg_if.b_y, seg_if.c_x, seg_if.c_y, seg_if.d_x,
                    seg_if.d_y}));
            if (res_if.valid && res_if.ready) begin
                if (expected_isects.size() == 0) begin
                    $error("unexpected result transaction");
                    n_errors++;
                end else begin
                    e = expected_isects.pop_front();
                    if (res_if.hit !== e.hit) begin
                        $error("hit: expected %0d, got %0d", e.hit, res_if.hit);
                        n_errors++;
                    end
                    if (res_if.point_valid !== e.pv) begin
                        $error("point_valid: expected %0d, got %0d", e.pv,
                               res_if.point_valid);
                        n_errors++;
                    end
                    if (res_if.point_x !== e.px) begin
                        $error("point_x: expected %0d, got %0d", e.px, res_if.point_x);
                        n_errors++;
                    end
                    if (res_if.point_y !== e.py) begin
                        $error("point_y: expected %0d, got %0d", e.py, res_if.point_y);
                        n_errors++;
                    end
                end
            end
        end
    end

    // watchdog on transaction-free cycles
    always @(posedge i_clk) begin
        if ((seg_if.valid && seg_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // end of run
    initial begin
        n_errors    = 0;
        idle_cycles = 0;
        wait (stim_done && pending_pairs.size() == 0);
        @(posedge i_clk);
        wait (!seg_if.valid);
        wait (expected_isects.size() == 0);
        repeat (40) @(posedge i_clk);
        if (n_errors == 0 && expected_isects.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
